### hdl/lbrl_pkg.sv
`default_nettype none

package lbrl_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERMANENT_POLICY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_LEVEL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAK_RATE        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_TTL        = 3'd4;

  localparam logic [31:0] ONE_Q16     = 32'h0001_0000;
  localparam logic [31:0] LEVEL_MAX   = 32'hFFFF_FFFF;
  localparam logic [31:0] TENTH_MULT  = 32'hCCCC_CCCD;
  localparam int unsigned TENTH_SHIFT = 35;

  localparam logic [31:0] BURST_RST   = 32'd6553600;
  localparam logic [31:0] RATE_RST    = 32'd65536;
  localparam logic [31:0] TTL_RST     = 32'd3600;
  localparam logic [28:0] TENTH_RST   = 29'd655360;
  localparam logic [31:0] REOPEN_RST  = 32'd5898240;

  typedef enum logic [1:0] {
    VERDICT_PASS     = 2'd0,
    VERDICT_NEW      = 2'd1,
    VERDICT_EXISTING = 2'd2
  } verdict_e;

  typedef struct packed {
    logic        enable;
    logic        permanent;
    logic [31:0] burst;
    logic [31:0] rate;
    logic [31:0] ttl;
    logic [31:0] reopen;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic        blocked;
    logic [31:0] level;
    logic [31:0] last;
  } entry_t;

  typedef struct packed {
    logic        wr_en;
    entry_t      entry;
    verdict_e    verdict;
    logic [31:0] level;
  } upd_t;

endpackage

`default_nettype wire

### hdl/lbrl_cfg_regs.sv
`default_nettype none

module lbrl_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           wr_en_i,
  input  wire logic [lbrl_pkg::CFG_IDX_W-1:0] wr_index_i,
  input  wire logic [31:0]                    wr_data_i,
  output lbrl_pkg::cfg_t                      cfg_o,
  output logic                                settling_o
);

  logic        enable_q;
  logic        permanent_q;
  logic [31:0] burst_q;
  logic [31:0] rate_q;
  logic [31:0] ttl_q;
  logic [28:0] tenth_q;
  logic [31:0] reopen_q;
  logic [1:0]  settle_q;
  logic [1:0]  settle_d;

  logic [63:0] tenth_prod;
  logic [32:0] tenth_x10;
  logic        tenth_exact;

  // burst / 10 by reciprocal, exact for 32-bit operands
  assign tenth_prod  = {32'd0, burst_q} * {32'd0, lbrl_pkg::TENTH_MULT};
  assign tenth_x10   = {1'b0, tenth_q, 3'b000} + {3'b000, tenth_q, 1'b0};
  assign tenth_exact = (tenth_x10 == {1'b0, burst_q});

  always_comb begin
    settle_d = settle_q;
    if (wr_en_i && (wr_index_i == lbrl_pkg::CFG_BURST_LEVEL)) begin
      settle_d = 2'd2;
    end else if (settle_q != 2'd0) begin
      settle_d = settle_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b1;
      permanent_q <= 1'b1;
      burst_q     <= lbrl_pkg::BURST_RST;
      rate_q      <= lbrl_pkg::RATE_RST;
      ttl_q       <= lbrl_pkg::TTL_RST;
      tenth_q     <= lbrl_pkg::TENTH_RST;
      reopen_q    <= lbrl_pkg::REOPEN_RST;
      settle_q    <= 2'd0;
    end else begin
      settle_q <= settle_d;
      // nine tenths of burst: burst - ceil(burst / 10)
      tenth_q  <= tenth_prod[lbrl_pkg::TENTH_SHIFT +: 29];
      reopen_q <= burst_q - {3'b000, tenth_q} - {31'd0, ~tenth_exact};
      if (wr_en_i) begin
        case (wr_index_i)
          lbrl_pkg::CFG_LIMIT_ENABLE:     enable_q    <= wr_data_i[0];
          lbrl_pkg::CFG_PERMANENT_POLICY: permanent_q <= wr_data_i[0];
          lbrl_pkg::CFG_BURST_LEVEL:      burst_q     <= wr_data_i;
          lbrl_pkg::CFG_LEAK_RATE:        rate_q      <= wr_data_i;
          lbrl_pkg::CFG_BLOCK_TTL:        ttl_q       <= wr_data_i;
          default: ;
        endcase
      end
    end
  end

  assign cfg_o.enable    = enable_q;
  assign cfg_o.permanent = permanent_q;
  assign cfg_o.burst     = burst_q;
  assign cfg_o.rate      = rate_q;
  assign cfg_o.ttl       = ttl_q;
  assign cfg_o.reopen    = reopen_q;
  assign settling_o      = (settle_q != 2'd0);

endmodule

`default_nettype wire

### hdl/lbrl_bucket_mem.sv
`default_nettype none

module lbrl_bucket_mem #(
  parameter int unsigned NUM_BUCKETS = 1024,
  parameter int unsigned IDX_W       = 10
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_en_i,
  input  wire logic [IDX_W-1:0] rd_idx_i,
  output lbrl_pkg::entry_t      rd_entry_o,
  input  wire logic             wr_en_i,
  input  wire logic [IDX_W-1:0] wr_idx_i,
  input  wire lbrl_pkg::entry_t wr_entry_i,
  output logic                  clearing_o
);

  logic [1:0]  flag_mem [NUM_BUCKETS];
  logic [63:0] data_mem [NUM_BUCKETS];
  logic [1:0]  flag_rd_q;
  logic [63:0] data_rd_q;

  logic             clearing_q;
  logic [IDX_W-1:0] clr_cnt_q;

  // clearing pass over the flags after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == IDX_W'(NUM_BUCKETS - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      flag_mem[clr_cnt_q] <= 2'b00;
    end else if (wr_en_i) begin
      flag_mem[wr_idx_i] <= {wr_entry_i.valid, wr_entry_i.blocked};
    end
    if (rd_en_i) begin
      flag_rd_q <= flag_mem[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      data_mem[wr_idx_i] <= {wr_entry_i.level, wr_entry_i.last};
    end
    if (rd_en_i) begin
      data_rd_q <= data_mem[rd_idx_i];
    end
  end

  assign rd_entry_o.valid   = flag_rd_q[1];
  assign rd_entry_o.blocked = flag_rd_q[0];
  assign rd_entry_o.level   = data_rd_q[63:32];
  assign rd_entry_o.last    = data_rd_q[31:0];
  assign clearing_o         = clearing_q;

endmodule

`default_nettype wire

### hdl/lbrl_update.sv
`default_nettype none

module lbrl_update (
  input  wire lbrl_pkg::cfg_t   cfg_i,
  input  wire lbrl_pkg::entry_t cur_i,
  input  wire logic [31:0]      now_i,
  output lbrl_pkg::upd_t        upd_o
);

  logic        later;
  logic [31:0] elapsed;
  logic [63:0] leak;
  logic [31:0] leaked;
  logic [32:0] inc_sum;
  logic [31:0] inc_level;

  assign later   = (cur_i.last < now_i);
  assign elapsed = now_i - cur_i.last;
  assign leak    = {32'd0, cfg_i.rate} * {32'd0, elapsed};

  always_comb begin
    leaked = cur_i.level;
    if (later) begin
      if (leak >= {32'd0, cur_i.level}) begin
        leaked = 32'd0;
      end else begin
        leaked = cur_i.level - leak[31:0];
      end
    end
  end

  assign inc_sum   = {1'b0, leaked} + {1'b0, lbrl_pkg::ONE_Q16};
  assign inc_level = inc_sum[32] ? lbrl_pkg::LEVEL_MAX : inc_sum[31:0];

  always_comb begin
    upd_o.wr_en         = 1'b0;
    upd_o.entry         = cur_i;
    upd_o.verdict       = lbrl_pkg::VERDICT_PASS;
    upd_o.level         = 32'd0;
    if (!cur_i.valid) begin
      upd_o.wr_en         = 1'b1;
      upd_o.entry.valid   = 1'b1;
      upd_o.entry.blocked = 1'b0;
      upd_o.entry.level   = lbrl_pkg::ONE_Q16;
      upd_o.entry.last    = now_i;
      upd_o.level         = lbrl_pkg::ONE_Q16;
    end else if (!cfg_i.enable) begin
      upd_o.level = cur_i.blocked ? 32'd0 : cur_i.level;
    end else if (cur_i.blocked) begin
      if (later && (elapsed >= cfg_i.ttl)) begin
        // reopen
        upd_o.wr_en         = 1'b1;
        upd_o.entry.blocked = 1'b0;
        upd_o.entry.level   = cfg_i.reopen;
        upd_o.entry.last    = now_i;
        upd_o.level         = cfg_i.reopen;
      end else begin
        upd_o.verdict = lbrl_pkg::VERDICT_EXISTING;
      end
    end else begin
      upd_o.wr_en      = 1'b1;
      upd_o.entry.last = now_i;
      if (leaked >= cfg_i.burst) begin
        upd_o.verdict       = lbrl_pkg::VERDICT_NEW;
        upd_o.entry.level   = leaked;
        upd_o.entry.blocked = cfg_i.permanent;
        upd_o.level         = cfg_i.permanent ? 32'd0 : leaked;
      end else begin
        upd_o.entry.level = inc_level;
        upd_o.level       = inc_level;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/leaky_bucket_rate_limiter.sv
// a start transfer is registered into s1, and its result is registered again before it strobes on valid_o
// throughput: one request per cycle while busy is low, same-bucket back-to-back requests are forwarded
// after reset busy stays high while the bucket flags are cleared
// a burst_level write holds busy while the reopen level settles
// results are shown for one cycle only, the receiver cannot stall
`default_nettype none

module leaky_bucket_rate_limiter #(
  parameter int unsigned NUM_BUCKETS = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [9:0]                     bucket_index_i,
  input  wire logic [31:0]                    timestamp_i,
  output logic                                valid_o,
  output logic [1:0]                          verdict_o,
  output logic [31:0]                         level_after_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [lbrl_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]                    cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(NUM_BUCKETS);

  lbrl_pkg::cfg_t   cfg;
  lbrl_pkg::entry_t rd_entry;
  lbrl_pkg::entry_t cur_entry;
  lbrl_pkg::upd_t   upd;

  logic settling;
  logic clearing;
  logic accept;

  logic [9:0]       red_index;
  logic [IDX_W-1:0] in_idx;

  logic             s1_valid_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic [31:0]      s1_now_q;

  logic             fwd_valid_q;
  logic [IDX_W-1:0] fwd_idx_q;
  lbrl_pkg::entry_t fwd_entry_q;

  logic              out_valid_q;
  lbrl_pkg::verdict_e verdict_q;
  logic [31:0]       level_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = clearing | settling;
  assign accept      = start & ~busy;

  // bucket index modulo NUM_BUCKETS by conditional subtraction
  always_comb begin
    red_index = bucket_index_i;
    for (int k = 9; k >= 0; k--) begin
      if (32'(red_index) >= (32'(NUM_BUCKETS) << k)) begin
        red_index = 10'(32'(red_index) - (32'(NUM_BUCKETS) << k));
      end
    end
  end

  assign in_idx = IDX_W'(red_index);

  lbrl_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i & cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg),
    .settling_o (settling)
  );

  lbrl_bucket_mem #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .IDX_W       (IDX_W)
  ) u_bucket_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_idx_i   (in_idx),
    .rd_entry_o (rd_entry),
    .wr_en_i    (s1_valid_q & upd.wr_en),
    .wr_idx_i   (s1_idx_q),
    .wr_entry_i (upd.entry),
    .clearing_o (clearing)
  );

  // previous request wrote this bucket on the edge of our read
  assign cur_entry = (fwd_valid_q && (fwd_idx_q == s1_idx_q)) ? fwd_entry_q : rd_entry;

  lbrl_update u_update (
    .cfg_i (cfg),
    .cur_i (cur_entry),
    .now_i (s1_now_q),
    .upd_o (upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= accept;
      fwd_valid_q <= s1_valid_q & upd.wr_en;
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_idx_q <= in_idx;
      s1_now_q <= timestamp_i;
    end
    fwd_idx_q   <= s1_idx_q;
    fwd_entry_q <= upd.entry;
    verdict_q   <= upd.verdict;
    level_q     <= upd.level;
  end

  assign valid_o       = out_valid_q;
  assign verdict_o     = verdict_q;
  assign level_after_o = level_q;

endmodule

`default_nettype wire

### hdl/lbrl_checker.sv
`default_nettype none

module lbrl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        valid_o,
  input wire logic [1:0]  verdict_o,
  input wire logic [31:0] level_after_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 valid_o)
    else $error("accepted request gave no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, 2))
    else $error("result without a matching transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (verdict_o == lbrl_pkg::VERDICT_EXISTING)) |-> (level_after_o == 32'd0))
    else $error("existing block reports a nonzero level");

  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> busy)
    else $error("not busy while flags are cleared");

endmodule

bind leaky_bucket_rate_limiter lbrl_checker u_lbrl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .valid_o       (valid_o),
  .verdict_o     (verdict_o),
  .level_after_o (level_after_o)
);

`default_nettype wire

### sim/tb_leaky_bucket_rate_limiter.sv
`default_nettype none

module tb_leaky_bucket_rate_limiter;

  localparam int unsigned NUM_BUCKETS = 1024;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned PHASE_ITEMS = 300;
  localparam logic [lbrl_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef struct packed {
    logic [9:0]  bucket;
    logic [31:0] stamp;
  } request_t;

  typedef struct packed {
    lbrl_pkg::verdict_e verdict;
    logic [31:0]        level;
  } outcome_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  logic [9:0]                     bucket_index_i = '0;
  logic [31:0]                    timestamp_i = '0;
  logic                           valid_o;
  logic [1:0]                     verdict_o;
  logic [31:0]                    level_after_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [lbrl_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0]                    cfg_data_i = '0;

  leaky_bucket_rate_limiter #(
    .NUM_BUCKETS(NUM_BUCKETS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .bucket_index_i(bucket_index_i),
    .timestamp_i   (timestamp_i),
    .valid_o       (valid_o),
    .verdict_o     (verdict_o),
    .level_after_o (level_after_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // predictor copy of the registers
  logic        lim_en;
  logic        perm_pol;
  logic [31:0] burst_r;
  logic [31:0] rate_r;
  logic [31:0] ttl_r;

  // predictor copy of the bucket table
  logic [31:0] fill_tbl [NUM_BUCKETS];
  logic [31:0] seen_tbl [NUM_BUCKETS];
  logic        blk_tbl  [NUM_BUCKETS];
  logic        live_tbl [NUM_BUCKETS];

  request_t    queued_reqs [$];
  outcome_t    predicted_q [$];
  request_t    drv_req;
  outcome_t    want;
  logic        req_taken = 1'b0;
  int unsigned gap_left = 0;
  bit          idle_on = 1'b1;

  logic [9:0]  hot_bucket [6];
  logic [31:0] tick;

  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned settings_used = 0;
  int unsigned verdict_count [3];
  int unsigned cycle_count = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic outcome_t limiter_step(logic [9:0] idx, logic [31:0] now);
    outcome_t    r;
    logic [31:0] cur;
    logic [31:0] elapsed;
    logic [63:0] drain;
    logic [63:0] wide;
    logic [32:0] bumped;
    r.verdict = lbrl_pkg::VERDICT_PASS;
    r.level   = '0;
    if (!live_tbl[idx]) begin
      live_tbl[idx] = 1'b1;
      blk_tbl[idx]  = 1'b0;
      fill_tbl[idx] = lbrl_pkg::ONE_Q16;
      seen_tbl[idx] = now;
      r.level       = lbrl_pkg::ONE_Q16;
    end else if (!lim_en) begin
      r.level = blk_tbl[idx] ? 32'd0 : fill_tbl[idx];
    end else if (blk_tbl[idx]) begin
      if (seen_tbl[idx] < now && (now - seen_tbl[idx]) >= ttl_r) begin
        wide          = 64'(burst_r) * 64'd9 / 64'd10;
        fill_tbl[idx] = wide[31:0];
        seen_tbl[idx] = now;
        blk_tbl[idx]  = 1'b0;
        r.level       = wide[31:0];
      end else begin
        r.verdict = lbrl_pkg::VERDICT_EXISTING;
      end
    end else begin
      cur = fill_tbl[idx];
      if (seen_tbl[idx] < now) begin
        elapsed = now - seen_tbl[idx];
        drain   = 64'(rate_r) * 64'(elapsed);
        cur     = (drain >= 64'(cur)) ? 32'd0 : cur - drain[31:0];
      end
      seen_tbl[idx] = now;
      if (cur >= burst_r) begin
        r.verdict     = lbrl_pkg::VERDICT_NEW;
        fill_tbl[idx] = cur;
        if (perm_pol) begin
          blk_tbl[idx] = 1'b1;
        end else begin
          r.level = cur;
        end
      end else begin
        bumped        = {1'b0, cur} + {1'b0, lbrl_pkg::ONE_Q16};
        cur           = bumped[32] ? lbrl_pkg::LEVEL_MAX : bumped[31:0];
        fill_tbl[idx] = cur;
        r.level       = cur;
      end
    end
    return r;
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && (!start || req_taken)) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start    <= 1'b0;
      end else if (queued_reqs.size() != 0) begin
        drv_req = queued_reqs.pop_front();
        start          <= 1'b1;
        bucket_index_i <= drv_req.bucket;
        timestamp_i    <= drv_req.stamp;
        if (idle_on && $urandom_range(0, 3) == 0) begin
          gap_left <= $urandom_range(1, 8);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    req_taken <= rst_ni && start && !busy;
    if (rst_ni) begin
      if (valid_o === 1'b1) begin
        results_seen++;
        if (predicted_q.size() == 0) begin
          $error("result with none outstanding: verdict %0d level %h",
                 verdict_o, level_after_o);
          mismatches++;
        end else begin
          want = predicted_q.pop_front();
          if (verdict_o < 3) verdict_count[verdict_o]++;
          if (verdict_o !== want.verdict) begin
            $error("verdict: expected %0d, actual %0d", want.verdict, verdict_o);
            mismatches++;
          end
          if (level_after_o !== want.level) begin
            $error("level_after: expected %h, actual %h", want.level, level_after_o);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        predicted_q.push_back(limiter_step(bucket_index_i, timestamp_i));
      end
    end
  end

  task automatic write_reg(input logic [lbrl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      lbrl_pkg::CFG_LIMIT_ENABLE:     lim_en   = data[0];
      lbrl_pkg::CFG_PERMANENT_POLICY: perm_pol = data[0];
      lbrl_pkg::CFG_BURST_LEVEL:      burst_r  = data;
      lbrl_pkg::CFG_LEAK_RATE:        rate_r   = data;
      lbrl_pkg::CFG_BLOCK_TTL:        ttl_r    = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_regs(input logic en, input logic perm, input logic [31:0] burst,
                              input logic [31:0] rate, input logic [31:0] ttl);
    write_reg(lbrl_pkg::CFG_LIMIT_ENABLE, ($urandom & 32'hFFFF_FFFE) | 32'(en));
    write_reg(lbrl_pkg::CFG_PERMANENT_POLICY, ($urandom & 32'hFFFF_FFFE) | 32'(perm));
    write_reg(lbrl_pkg::CFG_BURST_LEVEL, burst);
    write_reg(lbrl_pkg::CFG_LEAK_RATE, rate);
    write_reg(lbrl_pkg::CFG_BLOCK_TTL, ttl);
    settings_used++;
  endtask

  task automatic drain_all();
    do @(negedge clk_i);
    while (queued_reqs.size() != 0 || start || predicted_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic send(input logic [9:0] bucket, input logic [31:0] stamp);
    queued_reqs.push_back('{bucket: bucket, stamp: stamp});
  endtask

  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 3) begin
      r.bucket = 10'($urandom);
      r.stamp  = $urandom;
    end else begin
      r.bucket = hot_bucket[$urandom_range(0, 5)];
      if (pick < 11) begin
        tick += $urandom_range(0, 1);
        r.stamp = tick;
      end else if (pick < 14) begin
        r.stamp = tick;
      end else if (pick < 16) begin
        tick += ttl_r + $urandom_range(0, 3);
        r.stamp = tick;
      end else if (pick < 17) begin
        r.stamp = tick - $urandom_range(1, 50);
      end else begin
        tick += $urandom_range(2, 60);
        r.stamp = tick;
      end
    end
    return r;
  endfunction

  task automatic random_phase(input int unsigned count);
    foreach (hot_bucket[i]) hot_bucket[i] = 10'($urandom);
    tick = $urandom;
    repeat (count) queued_reqs.push_back(random_request());
    drain_all();
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_leaky_bucket_rate_limiter: FAIL");
    $finish;
  end

  initial begin
    lim_en   = 1'b1;
    perm_pol = 1'b1;
    burst_r  = lbrl_pkg::BURST_RST;
    rate_r   = lbrl_pkg::RATE_RST;
    ttl_r    = lbrl_pkg::TTL_RST;
    foreach (live_tbl[i]) begin
      live_tbl[i] = 1'b0;
      blk_tbl[i]  = 1'b0;
    end
    foreach (verdict_count[i]) verdict_count[i] = 0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    do @(negedge clk_i); while (busy !== 1'b0);

    // reset settings: creation at both index ends, no leak, clamp, time going back
    send(10'd0, 32'd0);
    send(10'd1023, 32'hFFFF_FFFF);
    send(10'd0, 32'd0);
    send(10'd0, 32'd5);
    send(10'd0, 32'd3);
    send(10'd1023, 32'd0);
    send(10'd1023, 32'hFFFF_FFFF);
    drain_all();

    // permanent block, existing block, reopen after ttl
    program_regs(1'b1, 1'b1, 32'h0002_0000, 32'h0000_8000, 32'd10);
    send(10'd5, 32'd100);
    send(10'd5, 32'd100);
    send(10'd5, 32'd100);
    send(10'd5, 32'd105);
    send(10'd5, 32'd99);
    send(10'd5, 32'd110);
    send(10'd5, 32'd110);
    send(10'd5, 32'd111);
    drain_all();

    // non-permanent block keeps its level
    program_regs(1'b1, 1'b0, 32'h0002_0000, 32'h0000_8000, 32'd10);
    send(10'd6, 32'd200);
    send(10'd6, 32'd200);
    send(10'd6, 32'd200);
    send(10'd6, 32'd202);
    drain_all();

    // limiting off: blocked, live and fresh buckets
    program_regs(1'b0, 1'b0, 32'h0002_0000, 32'h0000_8000, 32'd10);
    send(10'd5, 32'd500);
    send(10'd6, 32'd500);
    send(10'd7, 32'd500);
    drain_all();
    program_regs(1'b1, 1'b0, 32'h0002_0000, 32'h0000_8000, 32'd10);
    send(10'd6, 32'd500);
    send(10'd5, 32'd500);
    drain_all();
    write_reg(CFG_SPARE, $urandom);

    // top burst: reopen near the ceiling and climb
    program_regs(1'b1, 1'b1, 32'h0002_0000, 32'd0, 32'd0);
    send(10'd512, 32'd1);
    send(10'd512, 32'd1);
    send(10'd512, 32'd2);
    drain_all();
    program_regs(1'b1, 1'b1, 32'hFFFF_FFFF, 32'd0, 32'd0);
    send(10'd512, 32'd3);
    repeat (16) send(10'd512, $urandom);
    drain_all();

    // zero burst, full rate, longest ttl
    program_regs(1'b1, 1'b1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(10'd900, 32'd0);
    send(10'd900, 32'd0);
    send(10'd900, 32'hFFFF_FFFE);
    send(10'd900, 32'hFFFF_FFFF);
    random_phase(PHASE_ITEMS);

    program_regs(1'b1, 1'b1, 32'h0004_0000, 32'h0000_4000, 32'd20);
    random_phase(PHASE_ITEMS);
    program_regs(1'b1, 1'b0, 32'h0003_0000, 32'h0000_1000, 32'd5);
    random_phase(PHASE_ITEMS);
    program_regs(1'b0, 1'b1, 32'h0002_0000, 32'h0000_8000, 32'd8);
    random_phase(PHASE_ITEMS);
    program_regs(1'b1, 1'($urandom), ($urandom_range(1, 8) << 16) | 32'($urandom_range(0, 65535)),
                 $urandom_range(0, 32'h0002_0000), $urandom_range(1, 64));
    random_phase(PHASE_ITEMS);

    idle_on = 1'b0;
    program_regs(1'b1, 1'b1, 32'h0005_0000, 32'h0000_2000, 32'd30);
    random_phase(PHASE_ITEMS);

    repeat (8) @(negedge clk_i);
    $display("%0d requests checked under %0d register settings: %0d pass, %0d new block,",
             results_seen, settings_used, verdict_count[0], verdict_count[1]);
    $display("%0d existing block; top burst, reopen, disable and time-reversal cases included",
             verdict_count[2]);
    if (mismatches == 0 && predicted_q.size() == 0) begin
      $display("tb_leaky_bucket_rate_limiter: PASS");
    end else begin
      $display("tb_leaky_bucket_rate_limiter: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
